[rtl/core/sle_pkg.sv]
// shared types and constants for the sequential list engine
`default_nettype none
package sle_pkg;
  localparam int DEPTH = 32;
  localparam int DATA_WIDTH = 32;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0, OP_INSERT = 3'd1, OP_DELETE = 3'd2, OP_SEARCH = 3'd3,
    OP_REVERSE = 3'd4, OP_SORT = 3'd5, OP_DUMP = 3'd6, OP_CLEAR = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_BADPOS = 3'd2, ST_NOTFOUND = 3'd3, ST_EMPTY = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            wr_sel_val;  // write the captured input value, else read data or a held word
    logic            wr_from_rd;  // write the read data straight back
    logic            hold_a;      // capture read data into word a
    logic            hold_b;      // capture read data into word b
    logic            wr_from_b;   // write word b, else word a
    logic            min_load;    // capture read data as current minimum
    logic            load_val;    // capture input value
  } sle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            eq;          // read data equals input value
    logic            lt_min;      // read data below current minimum
  } sle_stat_t;
endpackage
`default_nettype wire

[rtl/core/sle_if.sv]
// valid/ready channel interfaces for the list engine
`default_nettype none
interface sle_in_if import sle_pkg::*; (input wire logic clk);
  logic                  valid;
  logic                  ready;
  logic [2:0]            opcode;
  logic [5:0]            position;
  logic signed [31:0]    value;
  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface sle_out_if import sle_pkg::*; (input wire logic clk);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [5:0]            found_position;
  logic signed [31:0]    element_value;
  logic [5:0]            entry_total;
  logic                  final_item;
  modport source (output valid, status, found_position, element_value, entry_total,
                  final_item, input ready);
  modport sink   (input valid, status, found_position, element_value, entry_total,
                  final_item, output ready);
endinterface
`default_nettype wire

[rtl/core/sle_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[rtl/core/sle_datapath.sv]
// list datapath: storage, word registers and compares
`default_nettype none
module sle_datapath import sle_pkg::*; (
  input  wire logic                  clk,
  input  wire sle_cmd_t              cmd,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  output logic      [DATA_WIDTH-1:0] rd_word,
  output sle_stat_t                  stat
);
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] val_r, a_r, b_r, min_r;
  logic [DATA_WIDTH-1:0] wr_data;

  // word registers
  always_ff @(posedge clk) begin
    if (cmd.load_val) val_r <= in_value;
    if (cmd.hold_a) a_r <= rd_data;
    if (cmd.hold_b) b_r <= rd_data;
    if (cmd.min_load) min_r <= rd_data;
  end

  assign wr_data = cmd.wr_sel_val ? val_r :
                   (cmd.wr_from_rd ? rd_data : (cmd.wr_from_b ? b_r : a_r));

  sle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data(wr_data),
    .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(rd_data)
  );

  // signed compares on read data
  assign stat.eq = (rd_data == val_r);
  assign stat.lt_min = ($signed(rd_data) < $signed(min_r));
  assign rd_word = rd_data;
endmodule
`default_nettype wire

[rtl/core/sle_ctrl.sv]
// list engine controller: opcode sequencing and result register
`default_nettype none
module sle_ctrl import sle_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sle_in_if.sink                     in_ch,
  sle_out_if.source                  out_ch,
  input  wire logic [DATA_WIDTH-1:0] rd_word,
  input  wire sle_stat_t             stat,
  output sle_cmd_t                   cmd
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SHIFT  = 10'b0000000010,  // read j-1 / write j (insert) or read j+1 / write j
    S_SRCH   = 10'b0000000100,
    S_REVA   = 10'b0000001000,
    S_REVB   = 10'b0000010000,
    S_SCAN   = 10'b0000100000,  // sort minimum scan
    S_SWAP   = 10'b0001000000,
    S_DUMP   = 10'b0010000000,
    S_RESP   = 10'b0100000000,
    S_WRITE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  opcode_t op_r, op_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, pos_r, pos_nxt;
  logic rdv_r, rdv_nxt;       // read data valid next cycle
  logic [CW-1:0] rdi_r, rdi_nxt;  // index of pending read data
  logic ov_r, ov_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic [5:0] opos_r, opos_nxt;
  logic [DATA_WIDTH-1:0] oval_r, oval_nxt;
  logic olast_r, olast_nxt;
  logic [CW-1:0] pos_in;

  assign pos_in = CW'(in_ch.position);
  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;

  assign out_ch.valid = ov_r;
  assign out_ch.status = ost_r;
  assign out_ch.found_position = opos_r;
  assign out_ch.element_value = oval_r;
  assign out_ch.entry_total = 6'(cnt_r);
  assign out_ch.final_item = olast_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0; rdv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt; rdv_r <= rdv_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt; i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; pos_r <= pos_nxt;
    rdi_r <= rdi_nxt; ost_r <= ost_nxt; opos_r <= opos_nxt; oval_r <= oval_nxt;
    olast_r <= olast_nxt;
  end

  // sequencing
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; op_nxt = op_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; pos_nxt = pos_r;
    rdv_nxt = 1'b0; rdi_nxt = rdi_r;
    ov_nxt = ov_r && !out_ch.ready;
    ost_nxt = ost_r; opos_nxt = opos_r; oval_nxt = oval_r; olast_nxt = olast_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          op_nxt = opcode_t'(in_ch.opcode);
          cmd.load_val = 1'b1;
          pos_nxt = pos_in;
          ost_nxt = ST_OK; opos_nxt = '0; oval_nxt = '0; olast_nxt = 1'b1;
          state_nxt = S_RESP;
          case (opcode_t'(in_ch.opcode))
            OP_APPEND: begin
              if (cnt_r == CW'(DEPTH)) ost_nxt = ST_FULL;
              else begin pos_nxt = cnt_r; state_nxt = S_WRITE; end
            end
            OP_INSERT: begin
              if (cnt_r == CW'(DEPTH)) ost_nxt = ST_FULL;
              else if (pos_in < CW'(1) || pos_in > cnt_r + CW'(1)) ost_nxt = ST_BADPOS;
              else begin j_nxt = cnt_r; pos_nxt = pos_in - CW'(1); state_nxt = S_SHIFT; end
            end
            OP_DELETE: begin
              if (cnt_r == '0) ost_nxt = ST_EMPTY;
              else if (pos_in < CW'(1) || pos_in > cnt_r) ost_nxt = ST_BADPOS;
              else begin j_nxt = pos_in - CW'(1); state_nxt = S_SHIFT; end
            end
            OP_SEARCH: begin
              if (cnt_r == '0) ost_nxt = ST_EMPTY;
              else begin i_nxt = '0; state_nxt = S_SRCH; end
            end
            OP_REVERSE: begin
              if (cnt_r > CW'(1)) begin
                i_nxt = '0; j_nxt = cnt_r - CW'(1); state_nxt = S_REVA;
              end
            end
            OP_SORT: begin
              if (cnt_r > CW'(1)) begin
                i_nxt = '0; j_nxt = '0; k_nxt = '0; state_nxt = S_SCAN;
              end
            end
            OP_DUMP: begin
              if (cnt_r == '0) ost_nxt = ST_EMPTY;
              else begin i_nxt = '0; state_nxt = S_DUMP; end
            end
            OP_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      S_WRITE: begin
        // insert or append final write of the new value
        cmd.wr_en = 1'b1; cmd.wr_sel_val = 1'b1; cmd.wr_addr = AW'(pos_r);
        cnt_nxt = cnt_r + CW'(1);
        state_nxt = S_RESP;
      end
      S_SHIFT: begin
        // one read then one write per moved entry
        if (op_r == OP_INSERT) begin
          if (!rdv_r) begin
            if (j_r > pos_r) begin
              cmd.rd_en = 1'b1; cmd.rd_addr = AW'(j_r - CW'(1)); rdv_nxt = 1'b1;
            end else state_nxt = S_WRITE;
          end else begin
            cmd.wr_from_rd = 1'b1;
            cmd.wr_en = 1'b1; cmd.wr_addr = AW'(j_r);
            j_nxt = j_r - CW'(1);
          end
        end else begin
          if (!rdv_r) begin
            if (j_r + CW'(1) < cnt_r) begin
              cmd.rd_en = 1'b1; cmd.rd_addr = AW'(j_r + CW'(1)); rdv_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_r - CW'(1); state_nxt = S_RESP;
            end
          end else begin
            cmd.wr_from_rd = 1'b1;
            cmd.wr_en = 1'b1; cmd.wr_addr = AW'(j_r);
            j_nxt = j_r + CW'(1);
          end
        end
      end
      S_SRCH: begin
        // issue reads in turn and check returned word
        if (rdv_r && stat.eq) begin
          ost_nxt = ST_OK; opos_nxt = 6'(rdi_r + CW'(1)); state_nxt = S_RESP;
        end else if (i_r < cnt_r) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = AW'(i_r); rdv_nxt = 1'b1; rdi_nxt = i_r;
          i_nxt = i_r + CW'(1);
        end else if (!rdv_r || rdi_r + CW'(1) == cnt_r) begin
          ost_nxt = ST_NOTFOUND; state_nxt = S_RESP;
        end
      end
      S_REVA: begin
        // read both ends of the pair
        if (i_r >= j_r) state_nxt = S_RESP;
        else if (!rdv_r) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = AW'(i_r); rdv_nxt = 1'b1; rdi_nxt = '0;
        end else if (rdi_r == '0) begin
          cmd.hold_a = 1'b1;
          cmd.rd_en = 1'b1; cmd.rd_addr = AW'(j_r); rdv_nxt = 1'b1; rdi_nxt = CW'(1);
        end else begin
          cmd.hold_b = 1'b1; state_nxt = S_REVB;
        end
      end
      S_REVB: begin
        // write swapped words, b to i first then a to j
        if (!rdv_r) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = AW'(i_r); cmd.wr_from_b = 1'b1; rdv_nxt = 1'b1;
        end else begin
          cmd.wr_en = 1'b1; cmd.wr_addr = AW'(j_r);
          i_nxt = i_r + CW'(1); j_nxt = j_r - CW'(1);
          state_nxt = (j_r - CW'(1) > i_r + CW'(1)) ? S_REVA : S_RESP;
        end
      end
      S_SCAN: begin
        // selection sort: j walks from i, k tracks minimum
        if (rdv_r) begin
          if (rdi_r == i_r) begin cmd.min_load = 1'b1; k_nxt = rdi_r; end
          else if (stat.lt_min) begin cmd.min_load = 1'b1; k_nxt = rdi_r; end
        end
        if (j_r < cnt_r) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = AW'(j_r); rdv_nxt = 1'b1; rdi_nxt = j_r;
          j_nxt = j_r + CW'(1);
        end else if (rdv_r) begin
          state_nxt = S_SWAP; rdi_nxt = '0;
        end
      end
      S_SWAP: begin
        // read a[i], then write min to i and a[i] to k
        if (k_r == i_r) rdi_nxt = CW'(2);
        if (rdi_r == '0 && k_r != i_r) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = AW'(i_r); rdi_nxt = CW'(1);
        end else if (rdi_r == CW'(1)) begin
          cmd.hold_a = 1'b1; rdi_nxt = CW'(3);
          cmd.rd_en = 1'b1; cmd.rd_addr = AW'(k_r);
        end else if (rdi_r == CW'(3)) begin
          cmd.hold_b = 1'b1; rdi_nxt = CW'(4);
        end else if (rdi_r == CW'(4)) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = AW'(i_r); cmd.wr_from_b = 1'b1; rdi_nxt = CW'(5);
        end else if (rdi_r == CW'(5)) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = AW'(k_r); rdi_nxt = CW'(2);
        end else if (rdi_r == CW'(2)) begin
          i_nxt = i_r + CW'(1); j_nxt = i_r + CW'(1);
          state_nxt = (i_r + CW'(2) < cnt_r) ? S_SCAN : S_RESP;
        end
      end
      S_DUMP: begin
        // read next entry once the result register is free
        if (rdv_r) begin
          ov_nxt = 1'b1; ost_nxt = ST_OK; opos_nxt = 6'(rdi_r + CW'(1));
          oval_nxt = rd_word; olast_nxt = (rdi_r + CW'(1) == cnt_r);
          if (rdi_r + CW'(1) == cnt_r) state_nxt = S_IDLE;
        end else if (!ov_r && i_r < cnt_r) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = AW'(i_r); rdv_nxt = 1'b1; rdi_nxt = i_r;
          i_nxt = i_r + CW'(1);
        end
      end
      S_RESP: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/sequential_list_engine_top.sv]
// Sequential list engine top: controller plus storage datapath.
// Insert and delete shift each moved entry with a read then a write; search reads entries in turn;
// dump reads one entry per result; reverse reads and swaps pairs from both ends inward.
// Sort is a selection sort, its pace set by the single ram read port.
// One item at a time; dump gives one result per entry, paced by the output ready.
// Synchronous active-low reset empties the list; ram contents are not cleared.
`default_nettype none
module sequential_list_engine_top import sle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sle_in_if.sink    in_ch,
  sle_out_if.source out_ch
);
  sle_cmd_t              cmd;
  sle_stat_t             stat;
  logic [DATA_WIDTH-1:0] rd_word;

  sle_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .rd_word(rd_word), .stat(stat), .cmd(cmd)
  );

  sle_datapath u_dp (
    .clk(clk), .cmd(cmd), .in_value(in_ch.value), .rd_word(rd_word), .stat(stat)
  );
endmodule
`default_nettype wire
